@@ rtl/gnss_receiver_failover_selector_unit_macros.svh @@
// Assertion helpers shared by the selector RTL.
`ifndef GNSS_RECEIVER_FAILOVER_SELECTOR_UNIT_MACROS_SVH
`define GNSS_RECEIVER_FAILOVER_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("selector check failed");

// Next-cycle implication, disabled during reset.
`define GFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("selector check failed");

`endif

@@ rtl/gnss_fs_pkg.sv @@
// ----------------------------------------------------------------------------
// GNSS failover selector package
// Shared types, register codes and reset values of the selector.
// ----------------------------------------------------------------------------
package gnss_fs_pkg;

  localparam int NUM_RX      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int MID_DEPTH_D = 2;
  localparam int OUT_DEPTH_D = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIMARY_INSTANCE  = 3'd0,
    REG_HYSTERESIS_US     = 3'd1,
    REG_MSG_TIMEOUT_US    = 3'd2,
    REG_MIN_FIX_TYPE      = 3'd3,
    REG_MAX_HORIZ_ACC_CM  = 3'd4,
    REG_MAX_VERT_ACC_CM   = 3'd5,
    REG_MAX_SPEED_ACC_CMS = 3'd6
  } cfg_reg_e;

  localparam logic        RST_PRIMARY  = 1'b0;
  localparam logic [31:0] RST_HYST     = 32'd10000000;
  localparam logic [31:0] RST_TIMEOUT  = 32'd1000000;
  localparam logic [3:0]  RST_MIN_FIX  = 4'd3;
  localparam logic [15:0] RST_MAX_HACC = 16'd500;
  localparam logic [15:0] RST_MAX_VACC = 16'd800;
  localparam logic [15:0] RST_MAX_SACC = 16'd100;

  localparam logic KIND_FIX  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic {
    OP_FIX  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic        kind;
    logic        instance_req;
    logic [63:0] time_us;
    logic [3:0]  fix_mode;
    logic [15:0] horiz_acc_cm;
    logic [15:0] vert_acc_cm;
    logic [15:0] speed_acc_cms;
  } gnss_fs_in_t;

  typedef struct packed {
    logic selection_valid;
    logic selected_instance;
    logic new_data;
    logic primary_healthy;
    logic secondary_healthy;
  } gnss_fs_out_t;

  typedef struct packed {
    op_e         op;
    logic        rx;
    logic [63:0] time_us;
    logic [3:0]  fix_mode;
    logic [15:0] horiz_acc;
    logic [15:0] vert_acc;
    logic [15:0] speed_acc;
  } gnss_fs_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/gnss_fs_fifo.sv @@
// ----------------------------------------------------------------------------
// GNSS failover selector queue
// Small first-in first-out queue with full and empty status.
// ----------------------------------------------------------------------------
module gnss_fs_fifo
  import gnss_fs_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output fifo_stat_t   stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/gnss_fs_front.sv @@
// ----------------------------------------------------------------------------
// GNSS failover selector front end
// Accepts input items, classifies them and forwards commands to the queue.
// ----------------------------------------------------------------------------
module gnss_fs_front
  import gnss_fs_pkg::*;
(
  input  logic         push,
  output logic         full,
  input  gnss_fs_in_t  in_data,
  input  fifo_stat_t   q_stat,
  output logic         q_push,
  output gnss_fs_cmd_t q_cmd
);

  assign full   = q_stat.full;
  assign q_push = push && !q_stat.full;

  // Ticks carry only the current time; fix fields are cleared.
  always_comb begin
    q_cmd         = '0;
    q_cmd.time_us = in_data.time_us;
    unique case (in_data.kind)
      KIND_FIX: begin
        q_cmd.op        = OP_FIX;
        q_cmd.rx        = in_data.instance_req;
        q_cmd.fix_mode  = in_data.fix_mode;
        q_cmd.horiz_acc = in_data.horiz_acc_cm;
        q_cmd.vert_acc  = in_data.vert_acc_cm;
        q_cmd.speed_acc = in_data.speed_acc_cms;
      end
      default: begin
        q_cmd.op = OP_TICK;
      end
    endcase
  end

endmodule

@@ rtl/gnss_fs_back.sv @@
// ----------------------------------------------------------------------------
// GNSS failover selector back end
// Holds receiver state and configuration, runs health checks and selection.
// ----------------------------------------------------------------------------
module gnss_fs_back
  import gnss_fs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  fifo_stat_t            cmd_stat,
  input  gnss_fs_cmd_t          cmd,
  output logic                  cmd_pop,
  input  fifo_stat_t            res_stat,
  output logic                  res_push,
  output gnss_fs_out_t          res_data
);

  logic        primary_r;
  logic [31:0] hyst_r, timeout_r;
  logic [3:0]  min_fix_r;
  logic [15:0] max_hacc_r, max_vacc_r, max_sacc_r;

  logic [63:0] fix_time_r  [NUM_RX];
  logic [3:0]  fix_kind_r  [NUM_RX];
  logic [15:0] hacc_r      [NUM_RX];
  logic [15:0] vacc_r      [NUM_RX];
  logic [15:0] sacc_r      [NUM_RX];
  logic [63:0] last_bad_r  [NUM_RX];
  logic [NUM_RX-1:0] fresh_r, fresh_nxt;
  logic        has_sel_r, has_sel_nxt;
  logic        chosen_r, chosen_nxt;

  logic [NUM_RX-1:0] bad, online;
  logic [63:0] age [NUM_RX];
  logic        pri, sec, pri_ok, cur;
  logic [63:0] since_bad;
  logic        is_fix, is_tick, exec;

  assign cfg_ready = 1'b1;

  assign is_fix  = (cmd.op == OP_FIX);
  assign is_tick = (cmd.op == OP_TICK);
  assign exec    = !cmd_stat.empty && (is_fix || !res_stat.full);
  assign cmd_pop = exec;

  always_comb begin
    for (int r = 0; r < NUM_RX; r++) begin
      age[r]    = cmd.time_us - fix_time_r[r];
      online[r] = (fix_time_r[r] != '0);
      bad[r]    = !online[r] || (fix_kind_r[r] < min_fix_r) ||
                  (hacc_r[r] > max_hacc_r) || (vacc_r[r] > max_vacc_r) ||
                  (sacc_r[r] > max_sacc_r) || (age[r] >= {32'd0, timeout_r});
    end
  end

  assign pri       = primary_r;
  assign sec       = ~primary_r;
  assign pri_ok    = !bad[pri];
  assign since_bad = cmd.time_us - last_bad_r[pri];

  always_comb begin
    has_sel_nxt = has_sel_r || pri_ok;
    cur         = has_sel_r ? chosen_r : pri;
    chosen_nxt  = chosen_r;
    if (has_sel_nxt) begin
      chosen_nxt = cur;
      if (cur == pri) begin
        if (!pri_ok && online[sec]) begin
          chosen_nxt = sec;
        end
      end else if (pri_ok && (since_bad >= {32'd0, hyst_r})) begin
        chosen_nxt = pri;
      end
    end
    fresh_nxt = fresh_r;
    if (has_sel_nxt) begin
      fresh_nxt[chosen_nxt] = 1'b0;
    end
  end

  assign res_push                   = exec && is_tick;
  assign res_data.selection_valid   = has_sel_nxt;
  assign res_data.selected_instance = has_sel_nxt && chosen_nxt;
  assign res_data.new_data          = has_sel_nxt && fresh_r[chosen_nxt];
  assign res_data.primary_healthy   = !bad[pri];
  assign res_data.secondary_healthy = !bad[sec];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r  <= RST_PRIMARY;
      hyst_r     <= RST_HYST;
      timeout_r  <= RST_TIMEOUT;
      min_fix_r  <= RST_MIN_FIX;
      max_hacc_r <= RST_MAX_HACC;
      max_vacc_r <= RST_MAX_VACC;
      max_sacc_r <= RST_MAX_SACC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRIMARY_INSTANCE:  primary_r  <= cfg_data[0];
        REG_HYSTERESIS_US:     hyst_r     <= cfg_data;
        REG_MSG_TIMEOUT_US:    timeout_r  <= cfg_data;
        REG_MIN_FIX_TYPE:      min_fix_r  <= cfg_data[3:0];
        REG_MAX_HORIZ_ACC_CM:  max_hacc_r <= cfg_data[15:0];
        REG_MAX_VERT_ACC_CM:   max_vacc_r <= cfg_data[15:0];
        REG_MAX_SPEED_ACC_CMS: max_sacc_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_RX; r++) begin
        fix_time_r[r] <= '0;
        fix_kind_r[r] <= '0;
        hacc_r[r]     <= '0;
        vacc_r[r]     <= '0;
        sacc_r[r]     <= '0;
        last_bad_r[r] <= '0;
      end
      fresh_r   <= '0;
      has_sel_r <= 1'b0;
      chosen_r  <= 1'b0;
    end else if (exec) begin
      if (is_fix) begin
        for (int r = 0; r < NUM_RX; r++) begin
          if (cmd.rx == 1'(r)) begin
            fix_time_r[r] <= cmd.time_us;
            fix_kind_r[r] <= cmd.fix_mode;
            hacc_r[r]     <= cmd.horiz_acc;
            vacc_r[r]     <= cmd.vert_acc;
            sacc_r[r]     <= cmd.speed_acc;
            fresh_r[r]    <= 1'b1;
          end
        end
      end else begin
        for (int r = 0; r < NUM_RX; r++) begin
          if (bad[r]) begin
            last_bad_r[r] <= cmd.time_us;
          end
        end
        fresh_r   <= fresh_nxt;
        has_sel_r <= has_sel_nxt;
        chosen_r  <= chosen_nxt;
      end
    end
  end

endmodule

@@ rtl/gnss_receiver_failover_selector_unit.sv @@
// ----------------------------------------------------------------------------
// GNSS receiver failover selector
// Picks one of two GNSS receivers from their fix quality and freshness.
// ----------------------------------------------------------------------------
// The input side is a queue: an item transfers when push is high and full is
// low. A fix update stores one receiver's fix and yields no result; a tick
// rechecks both receivers at the given time and yields one result. Results
// leave through a second queue: the oldest one is on out_data while empty is
// low and transfers when pop is high.
// Configuration writes transfer when cfg_valid and cfg_ready are both high;
// cfg_ready is always high. Write only while the block is idle.
// A tick first waits in the command queue; the combinational execution logic
// then takes it from the head of that queue and writes its result into the
// result queue, whose oldest entry is on out_data.
// The block takes one item per cycle while full is low; the execution stage
// retires one command per cycle unless a tick waits for room in the result queue.
// When the receiver of results stalls, the result queue fills, ticks wait
// in the command queue and full rises; fix updates ahead of the first
// waiting tick still drain.
// Synchronous reset restores register defaults and clears all receiver
// state and both queues; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "gnss_receiver_failover_selector_unit_macros.svh"

module gnss_receiver_failover_selector_unit
  import gnss_fs_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_D,
  parameter int OUT_DEPTH = OUT_DEPTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  gnss_fs_in_t           in_data,
  input  logic                  pop,
  output logic                  empty,
  output gnss_fs_out_t          out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMD_W = $bits(gnss_fs_cmd_t);
  localparam int RES_W = $bits(gnss_fs_out_t);

  fifo_stat_t   mid_stat, out_stat;
  logic         mid_push, mid_pop, res_push;
  gnss_fs_cmd_t front_cmd, mid_cmd;
  gnss_fs_out_t res_data;
  logic         out_no_sel;

  gnss_fs_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_stat  (mid_stat),
    .q_push  (mid_push),
    .q_cmd   (front_cmd)
  );

  gnss_fs_fifo #(
    .W     (CMD_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (front_cmd),
    .pop   (mid_pop),
    .rdata (mid_cmd),
    .stat  (mid_stat)
  );

  gnss_fs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_stat  (mid_stat),
    .cmd       (mid_cmd),
    .cmd_pop   (mid_pop),
    .res_stat  (out_stat),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  gnss_fs_fifo #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .pop   (pop),
    .rdata (out_data),
    .stat  (out_stat)
  );

  assign empty      = out_stat.empty;
  assign out_no_sel = !empty && !out_data.selection_valid;

  `GFS_ASSERT_NOW(a_fix_no_result, mid_pop && (mid_cmd.op == OP_FIX), !res_push)
  `GFS_ASSERT_NOW(a_push_has_room, res_push, !out_stat.full)
  `GFS_ASSERT_NOW(a_no_sel_zero, out_no_sel, !out_data.selected_instance && !out_data.new_data)
  `GFS_ASSERT_NEXT(a_tick_reaches_out, res_push, !empty)

endmodule
